/* design/sensor_background_calibration_sequencer_assert.svh */
// assertion macros for the background calibration sequencer
// used by sensor_background_calibration_sequencer.sv, needs i_clk and i_rst_n in scope
`ifndef SENSOR_BACKGROUND_CALIBRATION_SEQUENCER_ASSERT_SVH
`define SENSOR_BACKGROUND_CALIBRATION_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbcs assertion failed");

// next-cycle implication, checked outside reset
`define SBCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbcs assertion failed");

`endif

/* design/sbcs_pkg.sv */
// types and constants for the background calibration sequencer
// no dependencies; used by sensor_background_calibration_sequencer.sv
`default_nettype none

package sbcs_pkg;

    // sequencer phases as reported on the result item
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CLEAR = 3'd1,
        PH_SEND  = 3'd2,
        PH_WAIT  = 3'd3,
        PH_CHECK = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERROR = 3'd6
    } t_phase;

    // bus transaction performed by a step
    typedef enum logic [1:0] {
        BUS_NONE        = 2'd0,
        BUS_CLEAR_WRITE = 2'd1,
        BUS_CMD_WRITE   = 2'd2,
        BUS_STATUS_READ = 2'd3
    } t_bus_action;

    // item function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PROCESS = 1'b1;

    // tries
    localparam int unsigned MAX_TRIES = 3;
    localparam int unsigned TRY_W     = 4;
    localparam logic [TRY_W-1:0] TRY_SAT = {TRY_W{1'b1}};
    localparam logic [1:0]       TRIES_REPORT_MAX = 2'd3;

    // status flags
    localparam logic [7:0] FLAG_CAL_ERROR = 8'h80;
    localparam logic [7:0] FLAG_CAL_DONE  = 8'h20;

    // wait period and threshold
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned THR_W    = 26;
    localparam logic [9:0]          MS_PER_S          = 10'd1000;
    localparam logic [PERIOD_W-1:0] WAIT_PERIOD_RESET = 16'd4;
    localparam logic [THR_W-1:0]    WAIT_MS_RESET     = 26'd4000;

    // configuration port
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic REG_WAIT_PERIOD = 1'b0;

endpackage

`default_nettype wire

/* design/sensor_background_calibration_sequencer.sv */
// a result item passes through the input register and then the output register
// one item per cycle unless the output stalls; input register, one step of state logic,
// output register; a stalled output holds the input only when both registers are full
// reset: synchronous, active low; clears phase to idle, time stamp, try count, valids,
// and sets the wait period to 4 s (threshold 4000 ms)
// depends on sbcs_pkg and sensor_background_calibration_sequencer_assert.svh
`default_nettype none

`include "sensor_background_calibration_sequencer_assert.svh"

module sensor_background_calibration_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sbcs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sbcs_pkg::DATA_W-1:0]  pwdata,
    output logic      [sbcs_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_func,
    input  wire logic [31:0]                  i_now_ms,
    input  wire logic                         i_write_ok,
    input  wire logic                         i_error_read_ok,
    input  wire logic [7:0]                   i_error_status,
    input  wire logic                         i_cal_read_ok,
    input  wire logic [7:0]                   i_cal_status,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [2:0]                   o_phase,
    output logic      [1:0]                   o_bus_action,
    output logic                              o_done_res,
    output logic                              o_failed,
    output logic      [1:0]                   o_tries_used
);

    // configuration registers
    logic [sbcs_pkg::PERIOD_W-1:0] r_wait_period_s;
    logic [sbcs_pkg::THR_W-1:0]    r_wait_ms;
    logic                          cfg_wr;

    // input stage
    logic                        r_s1_valid;
    logic                        r_in_func;
    logic [sbcs_pkg::MS_W-1:0]   r_in_now_ms;
    logic                        r_in_write_ok;
    logic                        r_in_error_read_ok;
    logic [7:0]                  r_in_error_status;
    logic                        r_in_cal_read_ok;
    logic [7:0]                  r_in_cal_status;
    logic                        s1_move;
    logic                        in_take;

    // sequencer state
    sbcs_pkg::t_phase            r_phase;
    sbcs_pkg::t_phase            n_phase;
    logic [sbcs_pkg::MS_W-1:0]   r_wait_start_ms;
    logic [sbcs_pkg::MS_W-1:0]   n_wait_start_ms;
    logic [sbcs_pkg::TRY_W-1:0]  r_retry_cnt;
    logic [sbcs_pkg::TRY_W-1:0]  n_retry_cnt;
    logic [sbcs_pkg::TRY_W-1:0]  retry_inc;
    sbcs_pkg::t_bus_action       n_bus;
    logic [sbcs_pkg::MS_W-1:0]   elapsed_ms;
    logic                        wait_expired;
    logic                        check_fail;

    // output register
    logic                        r_out_valid;
    sbcs_pkg::t_phase            r_out_phase;
    sbcs_pkg::t_bus_action       r_out_bus;
    logic [1:0]                  r_out_tries;
    logic [1:0]                  n_tries_rep;

    // apb access, always ready; a write goes straight into the configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[sbcs_pkg::ADDR_W-1:2] == sbcs_pkg::REG_WAIT_PERIOD);

    always_comb begin
        if (paddr[sbcs_pkg::ADDR_W-1:2] == sbcs_pkg::REG_WAIT_PERIOD) begin
            prdata = {{(sbcs_pkg::DATA_W - sbcs_pkg::PERIOD_W){1'b0}}, r_wait_period_s};
        end else begin
            prdata = '0;
        end
    end

    // wait period and its millisecond threshold, product registered on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_period_s <= sbcs_pkg::WAIT_PERIOD_RESET;
            r_wait_ms       <= sbcs_pkg::WAIT_MS_RESET;
        end else if (cfg_wr) begin
            r_wait_period_s <= pwdata[sbcs_pkg::PERIOD_W-1:0];
            r_wait_ms       <= sbcs_pkg::THR_W'(pwdata[sbcs_pkg::PERIOD_W-1:0])
                             * sbcs_pkg::THR_W'(sbcs_pkg::MS_PER_S);
        end
    end

    // pipeline flow control
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_func          <= i_func;
            r_in_now_ms        <= i_now_ms;
            r_in_write_ok      <= i_write_ok;
            r_in_error_read_ok <= i_error_read_ok;
            r_in_error_status  <= i_error_status;
            r_in_cal_read_ok   <= i_cal_read_ok;
            r_in_cal_status    <= i_cal_status;
        end
    end

    // elapsed time since the stamp, modulo 2^32
    assign elapsed_ms   = r_in_now_ms - r_wait_start_ms;
    assign wait_expired = elapsed_ms >= {{(sbcs_pkg::MS_W - sbcs_pkg::THR_W){1'b0}}, r_wait_ms};
    assign check_fail   = !r_in_error_read_ok || !r_in_cal_read_ok
                       || ((r_in_error_status & sbcs_pkg::FLAG_CAL_ERROR) != 8'h00);
    assign retry_inc    = (r_retry_cnt == sbcs_pkg::TRY_SAT) ? r_retry_cnt
                                                              : r_retry_cnt + 1'b1;

    // next phase, stamp, try count and bus action for the item in the input register
    always_comb begin
        n_phase         = r_phase;
        n_wait_start_ms = r_wait_start_ms;
        n_retry_cnt     = r_retry_cnt;
        n_bus           = sbcs_pkg::BUS_NONE;
        if (r_in_func == sbcs_pkg::FUNC_START) begin
            n_phase         = sbcs_pkg::PH_CLEAR;
            n_retry_cnt     = '0;
            n_wait_start_ms = r_in_now_ms;
        end else begin
            case (r_phase)
                sbcs_pkg::PH_CLEAR: begin
                    n_bus   = sbcs_pkg::BUS_CLEAR_WRITE;
                    n_phase = r_in_write_ok ? sbcs_pkg::PH_SEND : sbcs_pkg::PH_ERROR;
                end
                sbcs_pkg::PH_SEND: begin
                    n_bus = sbcs_pkg::BUS_CMD_WRITE;
                    if (r_in_write_ok) begin
                        n_wait_start_ms = r_in_now_ms;
                        n_phase         = sbcs_pkg::PH_WAIT;
                    end else begin
                        n_phase = sbcs_pkg::PH_ERROR;
                    end
                end
                sbcs_pkg::PH_WAIT: begin
                    if (wait_expired) begin
                        n_phase = sbcs_pkg::PH_CHECK;
                    end
                end
                sbcs_pkg::PH_CHECK: begin
                    n_bus = sbcs_pkg::BUS_STATUS_READ;
                    if (check_fail) begin
                        n_phase = sbcs_pkg::PH_ERROR;
                    end else if ((r_in_cal_status & sbcs_pkg::FLAG_CAL_DONE) != 8'h00) begin
                        n_phase = sbcs_pkg::PH_DONE;
                    end else begin
                        n_retry_cnt = retry_inc;
                        if (retry_inc >= sbcs_pkg::TRY_W'(sbcs_pkg::MAX_TRIES)) begin
                            n_phase = sbcs_pkg::PH_ERROR;
                        end else begin
                            n_wait_start_ms = r_in_now_ms;
                            n_phase         = sbcs_pkg::PH_WAIT;
                        end
                    end
                end
                sbcs_pkg::PH_IDLE, sbcs_pkg::PH_DONE, sbcs_pkg::PH_ERROR: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = sbcs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // reported try count saturates at three
    assign n_tries_rep = (n_retry_cnt > sbcs_pkg::TRY_W'(sbcs_pkg::TRIES_REPORT_MAX))
                       ? sbcs_pkg::TRIES_REPORT_MAX : n_retry_cnt[1:0];

    // sequencer state, updated as an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= sbcs_pkg::PH_IDLE;
            r_wait_start_ms <= '0;
            r_retry_cnt     <= '0;
        end else if (s1_move) begin
            r_phase         <= n_phase;
            r_wait_start_ms <= n_wait_start_ms;
            r_retry_cnt     <= n_retry_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_phase <= n_phase;
            r_out_bus   <= n_bus;
            r_out_tries <= n_tries_rep;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_phase      = r_out_phase;
    assign o_bus_action = r_out_bus;
    assign o_done_res   = (r_out_phase == sbcs_pkg::PH_DONE);
    assign o_failed     = (r_out_phase == sbcs_pkg::PH_ERROR);
    assign o_tries_used = r_out_tries;

    // checks
    `SBCS_ASSERT_NOW(a_retry_bound, 1'b1, r_retry_cnt <= sbcs_pkg::TRY_W'(sbcs_pkg::MAX_TRIES))
    `SBCS_ASSERT_NOW(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid && i_out_stall)
    `SBCS_ASSERT_NEXT(a_state_tracks_out, s1_move, r_phase == r_out_phase)
    `SBCS_ASSERT_NOW(a_read_leaves_check,
        o_out_valid && (o_bus_action == sbcs_pkg::BUS_STATUS_READ),
        (o_phase == sbcs_pkg::PH_WAIT) || (o_phase == sbcs_pkg::PH_DONE)
            || (o_phase == sbcs_pkg::PH_ERROR))

endmodule

`default_nettype wire
